@@ rtl/vldq_pkg.sv @@
// shared types, codes and constants of the value list deque
`default_nettype none

package vldq_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 16;
    localparam int RESULT_LIMIT        = 16;
    localparam int VAL_W               = 32;

    typedef enum logic [3:0] {
        FN_PUSH     = 4'd0,
        FN_POP_BACK = 4'd1,
        FN_POP_FRNT = 4'd2,
        FN_READ_AT  = 4'd3,
        FN_PEEK_FRT = 4'd4,
        FN_PEEK_BCK = 4'd5,
        FN_ROT_BACK = 4'd6,
        FN_ROT_FWD  = 4'd7,
        FN_READ_ALL = 4'd8,
        FN_CLEAR    = 4'd9,
        FN_SORT     = 4'd10
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_EMPTY = 3'd1,
        STAT_RANGE = 3'd2,
        STAT_MODE  = 3'd3,
        STAT_FULL  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_LINEAR = 2'd0,
        KIND_CSLL   = 2'd1,
        KIND_CDLL   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SORT,
        S_DUMP
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_SHL,
        CELL_ROTF,
        CELL_ROTB,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic                     odd_phase;
        logic signed [VAL_W-1:0]  data;
    } cell_ctl_t;

    typedef struct packed {
        logic [3:0]               func;
        logic signed [VAL_W-1:0]  new_value;
        logic [7:0]               position;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  result_value;
        logic [2:0]               status;
        logic [4:0]               entries_held;
        logic                     last_of_run;
    } out_item_t;

endpackage

`default_nettype wire

@@ rtl/vldq_if.sv @@
// request, result and configuration channel interfaces
`default_nettype none

interface vldq_cmd_if;
    logic               valid;
    logic               ready;
    vldq_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface vldq_rsp_if;
    logic                valid;
    logic                ready;
    vldq_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface vldq_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] list_kind;

    modport source (output valid, output list_kind, input ready);
    modport sink (input valid, input list_kind, output ready);
endinterface

`default_nettype wire

@@ rtl/vldq_cell.sv @@
// one list position: holds a value, loads, shifts or compare-swaps with neighbors
`default_nettype none

module vldq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic                              clk,
    input  wire vldq_pkg::cell_ctl_t               ctl,
    input  wire logic [CW-1:0]                     count,
    input  wire logic signed [vldq_pkg::VAL_W-1:0] left_val,
    input  wire logic signed [vldq_pkg::VAL_W-1:0] right_val,
    output logic signed [vldq_pkg::VAL_W-1:0]      val
);
    import vldq_pkg::*;

    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);
    localparam logic          IS_ODD   = ((IDX % 2) == 1);

    logic signed [VAL_W-1:0] val_reg;
    logic signed [VAL_W-1:0] val_next;
    logic                    is_tail;
    logic                    in_list;
    logic                    right_in_list;

    assign is_tail       = (count == POS_NEXT);
    assign in_list       = (POS < count);
    assign right_in_list = (POS_NEXT < count);

    always_comb
    begin
        val_next = val_reg;
        unique case (ctl.op)
            CELL_HOLD: val_next = val_reg;
            CELL_PUSH:
            begin
                if (count == POS)
                    val_next = ctl.data;
            end
            CELL_SHL: val_next = right_val;
            CELL_ROTF: val_next = is_tail ? ctl.data : right_val;
            CELL_ROTB: val_next = (IDX == 0) ? ctl.data : left_val;
            CELL_SORT:
            begin
                // left member of the pair keeps the min, right member the max
                if (ctl.odd_phase == IS_ODD)
                begin
                    if (right_in_list && (val_reg > right_val))
                        val_next = right_val;
                end
                else
                begin
                    if (in_list && (left_val > val_reg))
                        val_next = left_val;
                end
            end
            default: val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

`default_nettype wire

@@ rtl/vldq_chain.sv @@
// row of list cells with neighbor links and the positional read select
`default_nettype none

module vldq_chain #(
    parameter int MAX_ENTRIES = 16,
    parameter int CW          = 5,
    parameter int IW          = 4
) (
    input  wire logic                              clk,
    input  wire vldq_pkg::cell_ctl_t               ctl,
    input  wire logic [CW-1:0]                     count,
    input  wire logic [IW-1:0]                     rd_idx,
    output logic signed [vldq_pkg::VAL_W-1:0]      rd_val,
    output logic signed [vldq_pkg::VAL_W-1:0]      front_val
);
    import vldq_pkg::*;

    logic signed [VAL_W-1:0] vals [MAX_ENTRIES];

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] left_val;
        logic signed [VAL_W-1:0] right_val;

        // end cells see themselves as the missing neighbor
        if (i == 0)
        begin : g_first
            assign left_val = vals[i];
        end
        else
        begin : g_mid_l
            assign left_val = vals[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign right_val = vals[i];
        end
        else
        begin : g_mid_r
            assign right_val = vals[i+1];
        end

        vldq_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (vals[i])
        );
    end

    assign rd_val    = vals[rd_idx];
    assign front_val = vals[0];

endmodule

`default_nettype wire

@@ rtl/value_list_deque_with_sort.sv @@
// top level of the value list deque with in-place sort
//
// cmd carries one request (func, new_value, position); rsp returns results
// (result_value, status, entries_held, last_of_run); cfg writes list_kind and
// is always ready. A request is taken when the block is idle, regardless of
// whether a previous result still sits in the output register.
// Push, pop, read at, peek, rotate and clear take the request when idle,
// then execute on the cell row and load the output register. Sort runs
// odd-even transposition on the cell row, entries_held phases, one per cycle,
// the last waiting for a free output register. Read all walks the row with
// the read index: min(entries_held, 16) results, one per unstalled cycle.
// Reset empties the list and sets list_kind to linear.
// When the receiver stalls, the result stays in the output register and the
// next execute, read-all or final sort step waits until it has been taken.
`default_nettype none

module value_list_deque_with_sort #(
    parameter int MAX_ENTRIES = vldq_pkg::DEFAULT_MAX_ENTRIES
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    vldq_cmd_if.sink    cmd,
    vldq_rsp_if.source  rsp,
    vldq_cfg_if.sink    cfg
);
    import vldq_pkg::*;

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = $clog2(MAX_ENTRIES);
    localparam int CMPW = (CW > 8) ? CW : 8;

    state_t                  state_reg, state_next;
    logic [1:0]              list_kind_reg;
    logic [3:0]              func_reg;
    logic signed [VAL_W-1:0] nv_reg;
    logic [7:0]              pos_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           phase_reg, phase_next;
    logic                    out_valid_reg;
    out_item_t               out_item_reg;

    cell_ctl_t               ctl;
    logic [IW-1:0]           rd_idx;
    logic signed [VAL_W-1:0] rd_val;
    logic signed [VAL_W-1:0] front_val;
    logic                    out_free;
    logic                    emit;
    logic signed [VAL_W-1:0] res_val;
    status_t                 res_stat;
    logic                    res_last;
    logic                    is_empty;
    logic                    is_full;
    logic [CW-1:0]           count_dec;
    logic [CW-1:0]           phase_inc;
    logic                    dump_last;
    logic                    accept;

    assign accept    = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CW'(MAX_ENTRIES));
    assign count_dec = count_reg - CW'(1);
    assign phase_inc = phase_reg + CW'(1);
    assign dump_last = (phase_inc == count_reg) ||
                       (CMPW'(phase_inc) == CMPW'(RESULT_LIMIT));

    vldq_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CW          (CW),
        .IW          (IW)
    ) u_chain (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_reg),
        .rd_idx    (rd_idx),
        .rd_val    (rd_val),
        .front_val (front_val)
    );

    // read index for the positional select
    always_comb
    begin
        rd_idx = '0;
        if (state_reg == S_DUMP)
            rd_idx = phase_reg[IW-1:0];
        else
        begin
            unique case (func_reg)
                FN_POP_BACK, FN_PEEK_BCK, FN_ROT_BACK: rd_idx = count_dec[IW-1:0];
                FN_READ_AT: rd_idx = IW'(pos_reg);
                FN_ROT_FWD: rd_idx = (count_reg > CW'(1)) ? IW'(1) : '0;
                default: rd_idx = '0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        ctl        = '{op: CELL_HOLD, odd_phase: 1'b0, data: '0};
        emit       = 1'b0;
        res_val    = '0;
        res_stat   = STAT_OK;
        res_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    unique case (func_reg)
                        FN_PUSH:
                        begin
                            if (is_full)
                                res_stat = STAT_FULL;
                            else
                            begin
                                ctl.op     = CELL_PUSH;
                                ctl.data   = nv_reg;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        FN_POP_BACK:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                            begin
                                res_val    = rd_val;
                                count_next = count_dec;
                            end
                        end
                        FN_POP_FRNT:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                            begin
                                res_val    = front_val;
                                ctl.op     = CELL_SHL;
                                count_next = count_dec;
                            end
                        end
                        FN_READ_AT:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            else if (CMPW'(pos_reg) >= CMPW'(count_reg))
                                res_stat = STAT_RANGE;
                            else
                                res_val = rd_val;
                        end
                        FN_PEEK_FRT:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                                res_val = front_val;
                        end
                        FN_PEEK_BCK:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                                res_val = rd_val;
                        end
                        FN_ROT_BACK:
                        begin
                            if (list_kind_reg != KIND_CDLL)
                                res_stat = STAT_MODE;
                            else if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                            begin
                                // back value moves to the front
                                ctl.op   = CELL_ROTB;
                                ctl.data = rd_val;
                                res_val  = rd_val;
                            end
                        end
                        FN_ROT_FWD:
                        begin
                            if (list_kind_reg != KIND_CDLL)
                                res_stat = STAT_MODE;
                            else if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                            begin
                                // front value moves to the back
                                ctl.op   = CELL_ROTF;
                                ctl.data = front_val;
                                res_val  = rd_val;
                            end
                        end
                        FN_READ_ALL:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                            begin
                                emit       = 1'b0;
                                phase_next = '0;
                                state_next = S_DUMP;
                            end
                        end
                        FN_CLEAR:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            count_next = '0;
                        end
                        FN_SORT:
                        begin
                            if (is_empty)
                                res_stat = STAT_EMPTY;
                            else
                            begin
                                emit       = 1'b0;
                                phase_next = '0;
                                state_next = S_SORT;
                            end
                        end
                        default:
                        begin
                            // unused codes give no result
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_SORT:
            begin
                ctl.odd_phase = phase_reg[0];
                if (phase_reg != count_dec)
                begin
                    ctl.op     = CELL_SORT;
                    phase_next = phase_inc;
                end
                else if (out_free)
                begin
                    // final phase goes together with the result
                    ctl.op     = CELL_SORT;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res_val    = rd_val;
                    res_last   = dump_last;
                    phase_next = phase_inc;
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            list_kind_reg <= KIND_LINEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (cfg.valid && cfg.ready)
                list_kind_reg <= cfg.list_kind;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.payload.func;
            nv_reg   <= cmd.payload.new_value;
            pos_reg  <= cmd.payload.position;
        end
        if (emit)
        begin
            out_item_reg.result_value <= (res_stat == STAT_OK) ? res_val : '0;
            out_item_reg.status       <= res_stat;
            out_item_reg.entries_held <= 5'(count_next);
            out_item_reg.last_of_run  <= res_last;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

endmodule

`default_nettype wire
